### src/crs_pkg.sv
`default_nettype none

package crs_pkg;

   // width of the column count register
   localparam int CFG_BITS = 5;

   // width of the reported standard deviation
   localparam int STD_BITS = 20;

   // operation codes of an input word
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

endpackage

`default_nettype wire

### src/column_running_statistics_top.sv
// Sample word: read, update, square and write back in order after acceptance;
// the next word is taken only once the write is done.
// Report word: per column a read, then the serial divide, multiply and square root
// unit, which stops after the mean below two rows, then the result register, which
// can stall on the output; the next word is taken once the last result is registered.
// Reset: counters, overflow flag and column valid bits clear; column count returns to 1.
`default_nettype none

module column_running_statistics_top import crs_pkg::*; #(
   parameter int COLUMNS = 16,
   parameter int SAMPLE_BITS = 20,
   parameter int ROW_BITS = 16,
   localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [IDX_W-1:0]              rsp_column_index,
   output logic [ROW_BITS-1:0]           rsp_rows,
   output logic signed [SAMPLE_BITS-1:0] rsp_minimum,
   output logic signed [SAMPLE_BITS-1:0] rsp_maximum,
   output logic signed [SAMPLE_BITS-1:0] rsp_mean_value,
   output logic [STD_BITS-1:0]           rsp_std_dev,
   output logic                          rsp_spread_valid,
   output logic                          rsp_overflowed,
   output logic                          rsp_last_column,
   input  logic                          csr_wr_en,
   input  logic [CFG_BITS-1:0]           csr_wr_data
);

   localparam int DEV_W = SAMPLE_BITS + 1 + ROW_BITS;
   localparam int SQ_W = 2 * SAMPLE_BITS + ROW_BITS;
   localparam int D_W = SAMPLE_BITS + 1;
   localparam int CNT_C = $clog2(COLUMNS + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] first;
      logic signed [SAMPLE_BITS-1:0] min;
      logic signed [SAMPLE_BITS-1:0] max;
      logic signed [DEV_W-1:0]       dev;
      logic [SQ_W-1:0]               sq;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_A_ADDR, ST_A_CALC, ST_A_MUL, ST_A_WR,
      ST_R_ADDR, ST_R_START, ST_R_WAIT, ST_R_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic [CFG_BITS-1:0]           cfg_ff, cfg_in;
   logic [IDX_W-1:0]              pos_ff, pos_in;
   logic [IDX_W-1:0]              col_ff, col_in;
   logic [ROW_BITS-1:0]           rows_ff, rows_in;
   logic                          ovf_ff, ovf_in;
   logic                          first_row_ff, first_row_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   entry_type                     ent_ff, ent_in;
   logic signed [D_W-1:0]         d_ff, d_in;
   logic [2*D_W-1:0]              dsq_ff, dsq_in;
   logic [COLUMNS-1:0]            valid_ff, valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]              rsp_col_ff, rsp_col_in;
   logic [ROW_BITS-1:0]           rsp_rows_ff, rsp_rows_in;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic [STD_BITS-1:0]           rsp_std_ff, rsp_std_in;
   logic                          rsp_spread_ff, rsp_spread_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;
   logic                          rsp_last_ff, rsp_last_in;

   // column memory, one synchronous read port and one write port
   entry_type mem [COLUMNS];
   entry_type ram_q_ff;
   logic      ram_v_ff;
   entry_type view;
   entry_type wdata;
   logic      mem_we;

   logic [CNT_C-1:0]              cols;
   logic [IDX_W-1:0]              pos_sel;
   logic                          accept;
   logic                          stat_busy;
   logic                          stat_start;
   logic signed [SAMPLE_BITS-1:0] stat_mean;
   logic [STD_BITS-1:0]           stat_std;
   logic signed [SAMPLE_BITS-1:0] nfirst, nmin, nmax;

   always_ff @(posedge clock) begin
      if (mem_we) mem[col_ff] <= wdata;
      ram_q_ff <= mem[col_ff];
      ram_v_ff <= valid_ff[col_ff];
   end

   // entry never written reads as cleared sums
   assign view = ram_v_ff ? ram_q_ff : '0;

   // effective column count
   always_comb begin
      if (cfg_ff == '0) cols = CNT_C'(1);
      else if (32'(cfg_ff) > COLUMNS) cols = CNT_C'(COLUMNS);
      else cols = CNT_C'(cfg_ff);
      pos_sel = (32'(pos_ff) >= 32'(cols)) ? '0 : pos_ff;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign accept = req_valid && req_ready;
   assign stat_start = state_ff == ST_R_START;
   assign mem_we = state_ff == ST_A_WR;

   // min, max and first value update, and the summed write data
   always_comb begin
      if (first_row_ff) begin
         nfirst = x_ff;
         nmin = x_ff;
         nmax = x_ff;
      end else begin
         nfirst = view.first;
         nmin = (x_ff < view.min) ? x_ff : view.min;
         nmax = (x_ff > view.max) ? x_ff : view.max;
      end
      wdata.first = ent_ff.first;
      wdata.min = ent_ff.min;
      wdata.max = ent_ff.max;
      wdata.dev = ent_ff.dev + DEV_W'(d_ff);
      wdata.sq = ent_ff.sq + SQ_W'(dsq_ff);
   end

   // control
   always_comb begin
      state_in = state_ff;
      cfg_in = csr_wr_en ? csr_wr_data : cfg_ff;
      pos_in = pos_ff;
      col_in = col_ff;
      rows_in = rows_ff;
      ovf_in = ovf_ff;
      first_row_in = first_row_ff;
      x_in = x_ff;
      ent_in = ent_ff;
      d_in = d_ff;
      dsq_in = dsq_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in = rsp_col_ff;
      rsp_rows_in = rsp_rows_ff;
      rsp_min_in = rsp_min_ff;
      rsp_max_in = rsp_max_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_std_in = rsp_std_ff;
      rsp_spread_in = rsp_spread_ff;
      rsp_ovf_in = rsp_ovf_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == OP_REPORT) begin
                  col_in = '0;
                  state_in = ST_R_ADDR;
               end else if (pos_sel == '0 && rows_ff == '1) begin
                  // row counter full: drop the word
                  ovf_in = 1'b1;
                  pos_in = '0;
               end else begin
                  if (pos_sel == '0) rows_in = rows_ff + ROW_BITS'(1);
                  first_row_in = rows_in == ROW_BITS'(1);
                  x_in = req_sample;
                  col_in = pos_sel;
                  pos_in = (32'(pos_sel) + 1 >= 32'(cols)) ? '0 : pos_sel + IDX_W'(1);
                  state_in = ST_A_ADDR;
               end
            end
         end
         ST_A_ADDR: state_in = ST_A_CALC;
         ST_A_CALC: begin
            ent_in.first = nfirst;
            ent_in.min = nmin;
            ent_in.max = nmax;
            ent_in.dev = view.dev;
            ent_in.sq = view.sq;
            d_in = D_W'(x_ff) - D_W'(nfirst);
            state_in = ST_A_MUL;
         end
         ST_A_MUL: begin
            dsq_in = (2*D_W)'(d_ff) * (2*D_W)'(d_ff);
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            valid_in[col_ff] = 1'b1;
            state_in = ST_IDLE;
         end
         ST_R_ADDR: state_in = ST_R_START;
         ST_R_START: begin
            ent_in = view;
            state_in = ST_R_WAIT;
         end
         ST_R_WAIT: begin
            if (!stat_busy) state_in = ST_R_EMIT;
         end
         ST_R_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in = col_ff;
               rsp_rows_in = rows_ff;
               rsp_min_in = (rows_ff == '0) ? '0 : ent_ff.min;
               rsp_max_in = (rows_ff == '0) ? '0 : ent_ff.max;
               rsp_mean_in = stat_mean;
               rsp_std_in = stat_std;
               rsp_spread_in = rows_ff > ROW_BITS'(1);
               rsp_ovf_in = ovf_ff;
               rsp_last_in = 32'(col_ff) + 1 == 32'(cols);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + IDX_W'(1);
                  state_in = ST_R_ADDR;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff <= CFG_BITS'(1);
         pos_ff <= '0;
         rows_ff <= '0;
         ovf_ff <= 1'b0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         pos_ff <= pos_in;
         rows_ff <= rows_in;
         ovf_ff <= ovf_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff <= col_in;
      first_row_ff <= first_row_in;
      x_ff <= x_in;
      ent_ff <= ent_in;
      d_ff <= d_in;
      dsq_ff <= dsq_in;
      rsp_col_ff <= rsp_col_in;
      rsp_rows_ff <= rsp_rows_in;
      rsp_min_ff <= rsp_min_in;
      rsp_max_ff <= rsp_max_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_std_ff <= rsp_std_in;
      rsp_spread_ff <= rsp_spread_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   // mean and spread unit
   crs_stats #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ROW_BITS(ROW_BITS)
   ) u_stats (
      .clock(clock),
      .reset(reset),
      .start(stat_start),
      .rows(rows_ff),
      .first(view.first),
      .dev_sum(view.dev),
      .sq_sum(view.sq),
      .busy(stat_busy),
      .mean_value(stat_mean),
      .std_dev(stat_std)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_rows = rsp_rows_ff;
   assign rsp_minimum = rsp_min_ff;
   assign rsp_maximum = rsp_max_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_std_dev = rsp_std_ff;
   assign rsp_spread_valid = rsp_spread_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_last_column = rsp_last_ff;

   // overflow flag is sticky
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared");

   // row count never goes down
   a_rows_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> rows_ff >= $past(rows_ff))
      else $error("row count decreased");

   // stats unit idle whenever a new word can enter
   a_stat_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat_busy)
      else $error("stats unit busy while idle");

endmodule

`default_nettype wire

### src/crs_stats.sv
`default_nettype none

module crs_stats import crs_pkg::*; #(
   parameter int SAMPLE_BITS = 20,
   parameter int ROW_BITS = 16,
   localparam int DEV_W = SAMPLE_BITS + 1 + ROW_BITS,
   localparam int SQ_W = 2 * SAMPLE_BITS + ROW_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ROW_BITS-1:0]           rows,
   input  logic signed [SAMPLE_BITS-1:0] first,
   input  logic signed [DEV_W-1:0]       dev_sum,
   input  logic [SQ_W-1:0]               sq_sum,
   output logic                          busy,
   output logic signed [SAMPLE_BITS-1:0] mean_value,
   output logic [STD_BITS-1:0]           std_dev
);

   localparam int P_W = 2 * DEV_W;
   localparam int DEN_W = 2 * ROW_BITS;
   localparam int H = (P_W + 1) / 2;
   localparam int R_W = 2 * H;
   localparam int CNT_W = $clog2(P_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_MEAN, S_MUL_A, S_MUL_B, S_DIFF, S_DIV, S_SQRT
   } state_type;

   state_type                     state_ff, state_in;
   logic [ROW_BITS-1:0]           n_ff, n_in;
   logic                          neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [SQ_W-1:0]               sq_ff, sq_in;
   logic [DEV_W-1:0]              mag_ff, mag_in;
   logic [DEN_W-1:0]              den_ff, den_in;
   logic [P_W-1:0]                acc_ff, acc_in;
   logic [P_W-1:0]                mcand_ff, mcand_in;
   logic [DEV_W-1:0]              mplier_ff, mplier_in;
   logic [P_W-1:0]                pa_ff, pa_in;
   logic [P_W-1:0]                qd_ff, qd_in;
   logic [DEN_W:0]                rem_ff, rem_in;
   logic [R_W-1:0]                rad_ff, rad_in;
   logic [H+1:0]                  srem_ff, srem_in;
   logic [H-1:0]                  root_ff, root_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [STD_BITS-1:0]           std_ff, std_in;

   // shared restoring divider step, one quotient bit per cycle
   logic [DEN_W-1:0] divisor;
   logic [DEN_W:0]   r2;
   logic             div_ge;
   logic [DEN_W:0]   rem_step;
   logic [P_W-1:0]   qd_step;
   // shift-add multiplier step
   logic [P_W-1:0]   acc_step;
   // digit-by-digit square root step
   logic [H+1:0]     s2, trial;
   logic [H+1:0]     srem_step;
   logic [H-1:0]     root_step;
   logic             last;
   logic signed [DEV_W:0] qs, tot;

   always_comb begin
      divisor = (state_ff == S_MEAN) ? DEN_W'(n_ff) : den_ff;
      r2 = {rem_ff[DEN_W-1:0], qd_ff[P_W-1]};
      div_ge = r2 >= {1'b0, divisor};
      rem_step = div_ge ? r2 - {1'b0, divisor} : r2;
      qd_step = {qd_ff[P_W-2:0], div_ge};
      acc_step = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
      s2 = {srem_ff[H-1:0], rad_ff[R_W-1:R_W-2]};
      trial = {root_ff, 2'b01};
      if (s2 >= trial) begin
         srem_step = s2 - trial;
         root_step = {root_ff[H-2:0], 1'b1};
      end else begin
         srem_step = s2;
         root_step = {root_ff[H-2:0], 1'b0};
      end
      last = cnt_ff == CNT_W'(1);
      qs = $signed({1'b0, qd_step[DEV_W-1:0]});
      if (neg_ff) qs = -qs;
      tot = qs + (DEV_W + 1)'(first_ff);
   end

   // sequencer: mean, then products, difference, divide and root; only the mean below two rows
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      neg_in = neg_ff;
      first_in = first_ff;
      sq_in = sq_ff;
      mag_in = mag_ff;
      den_in = den_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      pa_in = pa_ff;
      qd_in = qd_ff;
      rem_in = rem_ff;
      rad_in = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      mean_in = mean_ff;
      std_in = std_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in = rows;
               neg_in = dev_sum[DEV_W-1];
               first_in = first;
               sq_in = sq_sum;
               mag_in = dev_sum[DEV_W-1] ? DEV_W'(-dev_sum) : DEV_W'(dev_sum);
               den_in = DEN_W'(rows) * DEN_W'(rows - ROW_BITS'(1));
               std_in = '0;
               mean_in = '0;
               if (rows != '0) begin
                  qd_in = P_W'(mag_in) << (P_W - DEV_W);
                  rem_in = '0;
                  cnt_in = CNT_W'(DEV_W);
                  state_in = S_MEAN;
               end
            end
         end
         S_MEAN: begin
            qd_in = qd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last) begin
               mean_in = tot[SAMPLE_BITS-1:0];
               if (n_ff > ROW_BITS'(1)) begin
                  acc_in = '0;
                  mcand_in = P_W'(sq_ff);
                  mplier_in = DEV_W'(n_ff);
                  cnt_in = CNT_W'(ROW_BITS);
                  state_in = S_MUL_A;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_MUL_A: begin
            acc_in = acc_step;
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last) begin
               pa_in = acc_step;
               acc_in = '0;
               mcand_in = P_W'(mag_ff);
               mplier_in = mag_ff;
               cnt_in = CNT_W'(DEV_W);
               state_in = S_MUL_B;
            end
         end
         S_MUL_B: begin
            acc_in = acc_step;
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last) state_in = S_DIFF;
         end
         S_DIFF: begin
            // negative spread numerator counts as zero
            qd_in = (pa_ff >= acc_ff) ? pa_ff - acc_ff : '0;
            rem_in = '0;
            cnt_in = CNT_W'(P_W);
            state_in = S_DIV;
         end
         S_DIV: begin
            qd_in = qd_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last) begin
               rad_in = R_W'(qd_step);
               srem_in = '0;
               root_in = '0;
               cnt_in = CNT_W'(H);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rad_in = rad_ff << 2;
            srem_in = srem_step;
            root_in = root_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (last) begin
               if ((root_step >> STD_BITS) != '0) std_in = '1;
               else std_in = STD_BITS'(root_step);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff <= n_in;
      neg_ff <= neg_in;
      first_ff <= first_in;
      sq_ff <= sq_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      pa_ff <= pa_in;
      qd_ff <= qd_in;
      rem_ff <= rem_in;
      rad_ff <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      mean_ff <= mean_in;
      std_ff <= std_in;
   end

   assign busy = state_ff != S_IDLE;
   assign mean_value = mean_ff;
   assign std_dev = std_ff;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench import crs_pkg::*;;

   localparam int NCOL = 16;
   localparam int SBITS = 20;
   localparam int RBITS = 16;
   localparam int ROW_FULL = (1 << RBITS) - 1;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [3:0]              idx;
      logic [RBITS-1:0]        rows;
      logic signed [SBITS-1:0] mn;
      logic signed [SBITS-1:0] mx;
      logic signed [SBITS-1:0] mean;
      logic [STD_BITS-1:0]     sd;
      logic                    spread;
      logic                    ovf;
      logic                    last;
   } col_stats_type;

   typedef struct {
      bit                      func;
      logic signed [SBITS-1:0] smp;
      bit                      typed;
      col_stats_type           want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic signed [SBITS-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_column_index;
   logic [RBITS-1:0] rsp_rows;
   logic signed [SBITS-1:0] rsp_minimum, rsp_maximum, rsp_mean_value;
   logic [STD_BITS-1:0] rsp_std_dev;
   logic rsp_spread_valid, rsp_overflowed, rsp_last_column;
   logic csr_wr_en = 1'b0;
   logic [CFG_BITS-1:0] csr_wr_data = '0;

   column_running_statistics_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_column_index(rsp_column_index), .rsp_rows(rsp_rows),
      .rsp_minimum(rsp_minimum), .rsp_maximum(rsp_maximum),
      .rsp_mean_value(rsp_mean_value), .rsp_std_dev(rsp_std_dev),
      .rsp_spread_valid(rsp_spread_valid), .rsp_overflowed(rsp_overflowed),
      .rsp_last_column(rsp_last_column),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // statistics model state
   logic signed [SBITS-1:0] first_val[NCOL];
   logic signed [SBITS-1:0] col_min[NCOL];
   logic signed [SBITS-1:0] col_max[NCOL];
   longint dev_sum[NCOL];
   longint unsigned sq_sum[NCOL];
   int unsigned row_cnt = 0;
   int unsigned col_pos = 0;
   bit drop_flag = 0;
   logic [CFG_BITS-1:0] cols_reg = 5'd1;

   col_stats_type pending_stats[$];
   int mismatches = 0;
   int results_seen = 0;
   int burst_left = 0;

   function automatic int unsigned cols_active();
      if (cols_reg == 0) return 1;
      if (cols_reg > NCOL) return NCOL;
      return 32'(cols_reg);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // sample standard deviation, floor root of the integer variance
   function automatic logic [STD_BITS-1:0] spread_of_col(int c);
      logic [127:0] a, b, q;
      longint unsigned mag, r;
      mag = (dev_sum[c] < 0) ? longint'(-dev_sum[c]) : dev_sum[c];
      a = 128'(row_cnt) * 128'(sq_sum[c]);
      b = 128'(mag) * 128'(mag);
      if (a < b) return '0;
      q = (a - b) / (128'(row_cnt) * 128'(row_cnt - 1));
      r = int_sqrt(q[63:0]);
      return (r > 64'hFFFFF) ? 20'hFFFFF : r[19:0];
   endfunction

   task automatic stats_accumulate(logic signed [SBITS-1:0] x);
      int unsigned p, cols;
      longint d;
      cols = cols_active();
      p = col_pos;
      if (p >= cols) p = 0;
      if (p == 0) begin
         if (row_cnt >= ROW_FULL) begin
            drop_flag = 1;
            col_pos = 0;
            return;
         end
         row_cnt++;
      end
      if (row_cnt == 1) begin
         first_val[p] = x;
         col_min[p] = x;
         col_max[p] = x;
      end
      if (x > col_max[p]) col_max[p] = x;
      if (x < col_min[p]) col_min[p] = x;
      d = longint'(x) - longint'(first_val[p]);
      dev_sum[p] += d;
      sq_sum[p] += longint'(d * d);
      p++;
      col_pos = (p >= cols) ? 0 : p;
   endtask

   task automatic stats_report();
      int unsigned cols;
      col_stats_type s;
      longint unsigned mag, q;
      longint m;
      cols = cols_active();
      for (int c = 0; c < cols; c++) begin
         s = '0;
         s.idx = 4'(c);
         s.rows = RBITS'(row_cnt);
         if (row_cnt > 0) begin
            mag = (dev_sum[c] < 0) ? longint'(-dev_sum[c]) : dev_sum[c];
            q = mag / row_cnt;
            m = longint'(first_val[c]) + ((dev_sum[c] < 0) ? -longint'(q) : longint'(q));
            s.mn = col_min[c];
            s.mx = col_max[c];
            s.mean = m[SBITS-1:0];
         end
         if (row_cnt >= 2) begin
            s.sd = spread_of_col(c);
            s.spread = 1'b1;
         end
         s.ovf = drop_flag;
         s.last = (c == int'(cols) - 1);
         pending_stats.push_back(s);
      end
   endtask

   // offer one word and wait until it is taken
   task automatic send_word(bit func, logic signed [SBITS-1:0] smp);
      req_valid <= 1'b1;
      req_func <= func;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      if (func == OP_REPORT) stats_report();
      else stats_accumulate(smp);
   endtask

   task automatic sender_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // bursts of random length with random gaps
   task automatic send_bursty(bit func, logic signed [SBITS-1:0] smp);
      if (burst_left == 0) begin
         sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_word(func, smp);
   endtask

   // wait until every result is in, then let a dropped or silent word settle
   task automatic drain();
      sender_gap(1);
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cols(logic [CFG_BITS-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cols_reg = v;
   endtask

   function automatic logic signed [SBITS-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return -20'sd524288;
         1: return 20'sd524287;
         2: return SBITS'($urandom_range(0, 200) - 100);
         default: return SBITS'($urandom);
      endcase
   endfunction

   // receiver stall pattern, with one long hold-off
   int unsigned ready_mode = 0;
   int unsigned hold_cnt = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 20) begin
         hold_done <= 1'b1;
         hold_cnt <= 4000;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 40) == 0) ready_mode <= $urandom_range(0, 2);
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      col_stats_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         got = '{rsp_column_index, rsp_rows, rsp_minimum, rsp_maximum, rsp_mean_value,
                 rsp_std_dev, rsp_spread_valid, rsp_overflowed, rsp_last_column};
         if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: col %0d", got.idx);
         end else begin
            want = pending_stats.pop_front();
            if (got.idx != want.idx || got.rows != want.rows || got.mn != want.mn ||
                got.mx != want.mx || got.mean != want.mean || got.sd != want.sd ||
                got.spread != want.spread || got.ovf != want.ovf || got.last != want.last)
            begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp idx %0d rows %0d min %0d max %0d mean %0d %s",
                     want.idx, want.rows, want.mn, want.mx, want.mean, "");
                  $display("   exp sd %0d sv %0b ov %0b last %0b",
                     want.sd, want.spread, want.ovf, want.last);
                  $display("   got idx %0d rows %0d min %0d max %0d mean %0d",
                     got.idx, got.rows, got.mn, got.mx, got.mean);
                  $display("   got sd %0d sv %0b ov %0b last %0b",
                     got.sd, got.spread, got.ovf, got.last);
               end
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      plan_row_type plan[18];
      logic signed [SBITS-1:0] row_vals[16];
      logic [CFG_BITS-1:0] phase_cols[9];
      int n;

      for (int c = 0; c < NCOL; c++) begin
         first_val[c] = '0; col_min[c] = '0; col_max[c] = '0;
         dev_sum[c] = 0; sq_sum[c] = 0;
      end

      // directed: empty report, then a full first row of extremes, then report
      row_vals = '{-20'sd524288, 20'sd524287, 20'sd0, -20'sd1, 20'sd1, 20'h55555,
                   20'hAAAAA, 20'sd100, -20'sd100, 20'h7FFFE, 20'h80001, 20'sd2,
                   20'sd12345, -20'sd12345, 20'h0F0F0, 20'hF0F0F};
      plan[0] = '{func: OP_REPORT, smp: '0, typed: 1,
                  want: col_stats_type'{idx: 0, rows: 0, mn: 0, mx: 0, mean: 0, sd: 0,
                                        spread: 0, ovf: 0, last: 1}};
      for (int i = 0; i < 16; i++)
         plan[i + 1] = '{func: OP_SAMPLE, smp: row_vals[i], typed: 0, want: '0};
      plan[17] = '{func: OP_REPORT, smp: '1, typed: 0, want: '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 18; i++) begin
         if (i == 1) begin
            drain();
            write_cols(5'd16);
         end
         if (plan[i].typed) begin
            req_valid <= 1'b1;
            req_func <= plan[i].func;
            req_sample <= plan[i].smp;
            do @(posedge clock); while (!req_ready);
            pending_stats.push_back(plan[i].want);
         end else begin
            send_bursty(plan[i].func, plan[i].smp);
         end
      end

      // random phases over several column counts, register extremes included
      phase_cols = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd7, 5'd17, 5'd16, 5'd5};
      for (int ph = 0; ph < 9; ph++) begin
         drain();
         write_cols(phase_cols[ph]);
         n = $urandom_range(12, 22);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 6) == 0) send_bursty(OP_REPORT, rand_sample());
            else send_bursty(OP_SAMPLE, rand_sample());
         end
         send_bursty(OP_REPORT, rand_sample());
      end

      drain();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_stats.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
